### design/mfcs_pkg.sv
// shared types for the inline-code stripper
// one queue entry carries all results of one accepted request
// no dependencies
package mfcs_pkg;

  localparam int unsigned SLOTS = 3;
  localparam int unsigned CNT_W = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       line_end;
    logic       text_end;
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    slot_t [SLOTS-1:0] slot;
  } entry_t;

endpackage

### design/mfcs_front.sv
// front end: parse state machine, classifies each request into a result run
// depends on mfcs_pkg
module mfcs_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_byte_valid,
  input  logic            in_text_last,
  input  logic            q_full,
  output logic            push,
  output mfcs_pkg::entry_t push_entry
);
  import mfcs_pkg::*;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESCAPE = 3'd1;
  localparam logic [2:0] MODE_SKIP   = 3'd2;
  localparam logic [2:0] MODE_UPPER  = 3'd3;
  localparam logic [2:0] MODE_LOWER  = 3'd4;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_LBR   = 8'h7b;
  localparam logic [7:0] CH_RBR   = 8'h7d;
  localparam logic [7:0] CH_LU    = 8'h4c;
  localparam logic [7:0] CH_LL    = 8'h6c;
  localparam logic [7:0] CH_OU    = 8'h4f;
  localparam logic [7:0] CH_OL    = 8'h6f;
  localparam logic [7:0] CH_KU    = 8'h4b;
  localparam logic [7:0] CH_KL    = 8'h6b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  logic [2:0]       mode_r, mode_nxt;
  logic             lower_r, lower_nxt;
  logic [CNT_W-1:0] n;
  entry_t           ent;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ent       = '0;
    n         = '0;
    mode_nxt  = mode_r;
    lower_nxt = lower_r;
    if (in_byte_valid) begin
      unique case (mode_r)
        MODE_ESCAPE: begin
          mode_nxt = MODE_NORMAL;
          unique case (in_byte)
            CH_P: begin
              ent.slot[n].line_end = 1'b1;
              n = n + 2'd1;
            end
            CH_BSL, CH_LBR, CH_RBR: begin
              ent.slot[n].data = in_byte;
              n = n + 2'd1;
            end
            CH_TILDE: begin
              ent.slot[n].data = CH_SPACE;
              n = n + 2'd1;
            end
            CH_LU, CH_LL, CH_OU, CH_OL, CH_KU, CH_KL: begin
            end
            CH_S: begin
              mode_nxt  = MODE_UPPER;
              lower_nxt = 1'b0;
            end
            default: mode_nxt = MODE_SKIP;
          endcase
        end
        MODE_SKIP: begin
          if (in_byte == CH_SEMI) mode_nxt = MODE_NORMAL;
        end
        MODE_UPPER: begin
          priority if (in_byte == CH_SEMI) begin
            mode_nxt = MODE_NORMAL;
          end else if (in_byte == CH_CARET || in_byte == CH_HASH) begin
            mode_nxt = MODE_LOWER;
          end else begin
            ent.slot[n].data = in_byte;
            n = n + 2'd1;
          end
        end
        MODE_LOWER: begin
          priority if (in_byte == CH_SEMI) begin
            mode_nxt = MODE_NORMAL;
          end else if (in_byte != CH_CARET && in_byte != CH_HASH) begin
            // slash goes out once, ahead of the first lower byte
            if (!lower_r) begin
              ent.slot[n].data = CH_SLASH;
              n = n + 2'd1;
              lower_nxt = 1'b1;
            end
            ent.slot[n].data = in_byte;
            n = n + 2'd1;
          end else begin
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          priority if (in_byte == CH_BSL) begin
            mode_nxt = MODE_ESCAPE;
          end else if (in_byte != CH_LBR && in_byte != CH_RBR) begin
            ent.slot[n].data = in_byte;
            n = n + 2'd1;
          end else begin
          end
        end
      endcase
    end
    if (in_text_last) begin
      ent.slot[n].line_end = 1'b1;
      ent.slot[n].text_end = 1'b1;
      n = n + 2'd1;
      mode_nxt  = MODE_NORMAL;
      lower_nxt = 1'b0;
    end
    ent.cnt = n;
  end

  assign push       = accept && (ent.cnt != '0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      lower_r <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      lower_r <= lower_nxt;
    end
  end

endmodule

### design/mfcs_queue.sv
// short fifo of result runs between front and back
// depends on mfcs_pkg
module mfcs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mfcs_pkg::entry_t wr_data,
  input  logic             pop,
  output mfcs_pkg::entry_t rd_data,
  output logic             full,
  output logic             not_empty
);
  import mfcs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t          mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CW'(1);
    if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");
  a_no_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (wr_data.cnt != '0))
    else $error("run with no results queued");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

### design/mfcs_back.sv
// back end: unpacks one run per queue entry into single results
// depends on mfcs_pkg
module mfcs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  mfcs_pkg::entry_t q_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_line_end,
  output logic             out_text_end,
  output logic             out_run_last
);
  import mfcs_pkg::*;

  logic [CNT_W-1:0] idx_r;
  logic             valid_r;
  slot_t            slot_r;
  logic             last_r;
  logic             load;
  logic             is_last;

  assign load    = q_valid && (!valid_r || out_ready);
  assign is_last = (idx_r == q_entry.cnt - CNT_W'(1));
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? '0 : idx_r + CNT_W'(1);
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= q_entry.slot[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = slot_r.data;
  assign out_line_end = slot_r.line_end;
  assign out_text_end = slot_r.text_end;
  assign out_run_last = last_r;

endmodule

### design/mtext_format_code_stripper_unit.sv
// top level of the inline-code stripper for paragraph text
// depends on mfcs_pkg, mfcs_front, mfcs_queue, mfcs_back
//
// usage
//   input channel: one raw string byte per request (in_byte, in_byte_valid,
//   in_text_last) on in_valid/in_ready. a request with in_byte_valid low
//   carries no byte; with in_text_last high it still closes the string.
//   output channel: one result per request on out_valid/out_ready; a result
//   is a visible byte or a line end, out_text_end flags the final line end,
//   out_run_last flags the last result caused by one input request.
// path: an accepted request is written into the queue, and its results are then
//   loaded one by one from the queue into the output register
// throughput: one input request per cycle while out_ready stays high and each
//   request makes at most one result; a request that makes two or three
//   results is drained one result per cycle by the single output register,
//   and the queue absorbs the difference
// reset: synchronous, active low; parser returns to normal text mode and the
//   queue and output register are emptied
// stall: when out_ready is low the output holds; the queue keeps taking
//   requests until its QUEUE_DEPTH entries are full, then in_ready drops
module mtext_format_code_stripper_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_byte_valid,
  input  logic       in_text_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_line_end,
  output logic       out_text_end,
  output logic       out_run_last
);
  import mfcs_pkg::*;

  // front to queue
  logic   push;
  entry_t push_entry;
  logic   q_full;

  // queue to back
  logic   pop;
  entry_t head_entry;
  logic   q_valid;

  // parser: classifies each request into a run of up to three results
  mfcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_byte_valid (in_byte_valid),
    .in_text_last  (in_text_last),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  // decouples parsing from output stalls
  mfcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (push_entry),
    .pop       (pop),
    .rd_data   (head_entry),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // serializer with output register
  mfcs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_entry      (head_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_line_end (out_line_end),
    .out_text_end (out_text_end),
    .out_run_last (out_run_last)
  );

endmodule
